// ===== src/dltq_pkg.sv =====
`timescale 1ns / 1ps

package dltq_pkg;

	localparam int MAX_TASKS_DEF = 16;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_POP    = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_FIN
	} state_t;

	typedef struct packed {
		logic [31:0] id;
		logic [31:0] dly;
		logic [31:0] per;
	} ent_t;

	// Work token that travels down the cell row, one cell per cycle.
	typedef struct packed {
		op_t         op;
		logic        done;
		logic [31:0] id;
		logic [31:0] rem;
		logic [31:0] per;
		ent_t        carry;
	} tok_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] task_id;
		logic [31:0] delay;
		logic [31:0] period;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] popped_id;
		logic [31:0] popped_delay;
		logic [31:0] popped_period;
		logic        front_valid;
		logic [31:0] front_id;
		logic [31:0] front_delay;
		logic [31:0] front_period;
		logic [4:0]  entry_count;
	} out_item_t;

endpackage

// ===== src/dltq_in_if.sv =====
`timescale 1ns / 1ps

interface dltq_in_if import dltq_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/dltq_out_if.sv =====
`timescale 1ns / 1ps

interface dltq_out_if import dltq_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/dltq_cell.sv =====
`timescale 1ns / 1ps

module dltq_cell import dltq_pkg::*; #(
	parameter int MAX_TASKS = MAX_TASKS_DEF,
	parameter int INDEX = 0,
	localparam int CNT_W = $clog2(MAX_TASKS + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CNT_W-1:0] count,
	input  logic             tok_v_in,
	input  tok_t             tok_in,
	input  ent_t             right,
	output logic             tok_v_out,
	output tok_t             tok_out,
	output ent_t             ent
);

	localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

	ent_t ent_q, ent_d;
	tok_t tok_q, tok_d;
	logic tok_v_q;
	logic occupied, goes_after, match;

	always_comb begin
		ent_d = ent_q;
		tok_d = tok_in;
		occupied = IDX < count;
		goes_after = occupied && (ent_q.dly <= tok_in.rem);
		match = occupied && ((tok_in.op == OP_POP) || (ent_q.id == tok_in.id));
		if (tok_v_in) begin
			case (tok_in.op)
				OP_INSERT: begin
					if (tok_in.done) begin
						// Behind the new entry everything moves one cell toward the tail.
						ent_d = tok_in.carry;
						tok_d.carry = ent_q;
					end else if (goes_after) begin
						tok_d.rem = tok_in.rem - ent_q.dly;
					end else begin
						ent_d.id = tok_in.id;
						ent_d.dly = tok_in.rem;
						ent_d.per = tok_in.per;
						tok_d.carry.id = ent_q.id;
						tok_d.carry.dly = ent_q.dly - tok_in.rem;
						tok_d.carry.per = ent_q.per;
						tok_d.done = 1'b1;
					end
				end
				OP_REMOVE, OP_POP: begin
					if (tok_in.done) begin
						ent_d = right;
					end else if (match) begin
						// The successor inherits the removed delay, except on a pop.
						ent_d = right;
						ent_d.dly = right.dly + ((tok_in.op == OP_POP) ? 32'd0 : ent_q.dly);
						tok_d.done = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_v_q <= 1'b0;
		end else begin
			tok_v_q <= tok_v_in;
		end
	end

	always_ff @(posedge clk) begin
		ent_q <= ent_d;
		tok_q <= tok_d;
	end

	assign tok_v_out = tok_v_q;
	assign tok_out = tok_q;
	assign ent = ent_q;

endmodule

// ===== src/delta_list_timer_queue.sv =====
// Ordered timer queue in delta-list form, built as a row of MAX_TASKS cells, cell 0 holding the
// front entry. Insert, remove by id and pop send a work token down the row one cell per cycle;
// operations that change nothing (queue full on insert, empty queue on remove or pop, the no-op
// code) send no token and go straight to the result. One item is in work at a time; the result
// register lets a new item be taken while the previous result still waits. Every result reports
// the front entry and the count.
`timescale 1ns / 1ps

module delta_list_timer_queue import dltq_pkg::*; #(
	parameter int MAX_TASKS = MAX_TASKS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	dltq_in_if.sink   req,
	dltq_out_if.source rsp
);

	localparam int CNT_W = $clog2(MAX_TASKS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TASKS);

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_next;
	logic [MAX_TASKS:0] tok_v;
	tok_t tok [MAX_TASKS+1];
	ent_t ent [MAX_TASKS+1];

	logic launch_q;
	tok_t tok0_q;
	op_t op_in, op_q;
	status_t status_q, status_res;
	ent_t popped_q;
	logic walked_q, found_q;
	logic accept, walk_needed, load_res;
	out_item_t res_q;
	logic res_valid_q;

	assign tok_v[0] = launch_q;
	assign tok[0] = tok0_q;
	assign ent[MAX_TASKS] = '0;

	for (genvar k = 0; k < MAX_TASKS; k++) begin : g_cell
		dltq_cell #(
			.MAX_TASKS(MAX_TASKS),
			.INDEX(k)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.count(cnt_q),
			.tok_v_in(tok_v[k]),
			.tok_in(tok[k]),
			.right(ent[k+1]),
			.tok_v_out(tok_v[k+1]),
			.tok_out(tok[k+1]),
			.ent(ent[k])
		);
	end

	assign op_in = op_t'(req.data.operation);

	always_comb begin
		case (op_in)
			OP_INSERT: walk_needed = cnt_q < CNT_MAX;
			OP_REMOVE, OP_POP: walk_needed = cnt_q != '0;
			default: walk_needed = 1'b0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		req.ready = state_q == S_IDLE;
		accept = req.valid && (state_q == S_IDLE);
		load_res = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = walk_needed ? S_RUN : S_FIN;
				end
			end
			S_RUN: begin
				if (tok_v[MAX_TASKS]) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (!res_valid_q || rsp.ready) begin
					load_res = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cnt_next = cnt_q;
		status_res = status_q;
		if (walked_q) begin
			if (found_q) begin
				cnt_next = (op_q == OP_INSERT) ? cnt_q + CNT_W'(1) : cnt_q - CNT_W'(1);
			end else begin
				status_res = ST_NOT_FOUND;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			launch_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			launch_q <= accept && walk_needed;
			if (load_res) begin
				cnt_q <= cnt_next;
			end
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= op_in;
			walked_q <= walk_needed;
			found_q <= 1'b0;
			tok0_q.op <= op_in;
			tok0_q.done <= 1'b0;
			tok0_q.id <= req.data.task_id;
			tok0_q.rem <= req.data.delay;
			tok0_q.per <= req.data.period;
			tok0_q.carry <= '0;
			popped_q <= ((op_in == OP_POP) && (cnt_q != '0)) ? ent[0] : '0;
			case (op_in)
				OP_INSERT: status_q <= walk_needed ? ST_OK : ST_FULL;
				OP_REMOVE: status_q <= walk_needed ? ST_OK : ST_NOT_FOUND;
				OP_POP: status_q <= walk_needed ? ST_OK : ST_EMPTY;
				default: status_q <= ST_OK;
			endcase
		end else if (tok_v[MAX_TASKS]) begin
			found_q <= tok[MAX_TASKS].done;
		end
		if (load_res) begin
			res_q.status <= status_res;
			res_q.popped_id <= popped_q.id;
			res_q.popped_delay <= popped_q.dly;
			res_q.popped_period <= popped_q.per;
			res_q.front_valid <= cnt_next != '0;
			res_q.front_id <= (cnt_next != '0) ? ent[0].id : 32'd0;
			res_q.front_delay <= (cnt_next != '0) ? ent[0].dly : 32'd0;
			res_q.front_period <= (cnt_next != '0) ? ent[0].per : 32'd0;
			res_q.entry_count <= 5'(cnt_next);
		end
	end

	assign rsp.valid = res_valid_q;
	assign rsp.data = res_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX)
		else $error("entry count above capacity");

	a_single_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_v))
		else $error("more than one token in the cell row");

	a_exit_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		tok_v[MAX_TASKS] |-> state_q == S_RUN)
		else $error("token left the row outside a walk");

	a_fin_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) && (!res_valid_q || rsp.ready) |=> res_valid_q && (state_q == S_IDLE))
		else $error("finished item did not reach the result register");

endmodule

// ===== tb/dltq_checker.sv =====
`timescale 1ns / 1ps

module dltq_checker import dltq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	dltq_in_if   req_mon,
	dltq_out_if  rsp_mon,
	output int   mismatch_count,
	output int   reports_waiting
);

	localparam int DEPTH = MAX_TASKS_DEF;

	logic [31:0] slot_id [DEPTH];
	logic [31:0] slot_dly [DEPTH];
	logic [31:0] slot_per [DEPTH];
	int unsigned slot_count;

	out_item_t queue_reports[$];
	int errs;
	int waiting;

	assign mismatch_count  = errs;
	assign reports_waiting = waiting;

	function automatic void drop_slot(int unsigned pos);
		for (int unsigned k = pos; k + 1 < slot_count; k++) begin
			slot_id[k]  = slot_id[k + 1];
			slot_dly[k] = slot_dly[k + 1];
			slot_per[k] = slot_per[k + 1];
		end
		slot_count--;
	endfunction

	// Applies one operation to the local copy of the queue and returns the report.
	function automatic out_item_t apply_timer_op(in_item_t it);
		out_item_t r;
		int unsigned pos;
		longint unsigned acc;
		logic [31:0] rel;
		r = '0;
		r.status = ST_OK;
		pos = 0;
		acc = 0;
		case (op_t'(it.operation))
			OP_INSERT: begin
				if (slot_count >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					// Running totals are kept at 64 bits so they never wrap.
					while (pos < slot_count &&
					       acc + longint'(slot_dly[pos]) <= longint'(it.delay)) begin
						acc += slot_dly[pos];
						pos++;
					end
					rel = it.delay - acc[31:0];
					for (int unsigned k = slot_count; k > pos; k--) begin
						slot_id[k]  = slot_id[k - 1];
						slot_dly[k] = slot_dly[k - 1];
						slot_per[k] = slot_per[k - 1];
					end
					slot_id[pos]  = it.task_id;
					slot_dly[pos] = rel;
					slot_per[pos] = it.period;
					slot_count++;
					if (pos + 1 < slot_count)
						slot_dly[pos + 1] = slot_dly[pos + 1] - rel;
				end
			end
			OP_REMOVE: begin
				while (pos < slot_count && slot_id[pos] != it.task_id)
					pos++;
				if (pos >= slot_count) begin
					r.status = ST_NOT_FOUND;
				end else begin
					if (pos + 1 < slot_count)
						slot_dly[pos + 1] = slot_dly[pos + 1] + slot_dly[pos];
					drop_slot(pos);
				end
			end
			OP_POP: begin
				if (slot_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.popped_id     = slot_id[0];
					r.popped_delay  = slot_dly[0];
					r.popped_period = slot_per[0];
					drop_slot(0);
				end
			end
			default: begin
			end
		endcase
		if (slot_count > 0) begin
			r.front_valid  = 1'b1;
			r.front_id     = slot_id[0];
			r.front_delay  = slot_dly[0];
			r.front_period = slot_per[0];
		end
		r.entry_count = slot_count[4:0];
		return r;
	endfunction

	task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
			errs++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		out_item_t want;
		out_item_t got;
		if (!arst_n) begin
			slot_count = 0;
			errs = 0;
			waiting = 0;
			queue_reports.delete();
		end else begin
			// The result side is checked first so that a result can never be matched
			// against an item accepted at the same edge.
			if (rsp_mon.valid && rsp_mon.ready) begin
				got = rsp_mon.data;
				if (queue_reports.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h", $time, got);
					errs++;
				end else begin
					want = queue_reports.pop_front();
					check_field("status", 32'(want.status), 32'(got.status));
					check_field("popped_id", want.popped_id, got.popped_id);
					check_field("popped_delay", want.popped_delay, got.popped_delay);
					check_field("popped_period", want.popped_period, got.popped_period);
					check_field("front_valid", 32'(want.front_valid),
					            32'(got.front_valid));
					check_field("front_id", want.front_id, got.front_id);
					check_field("front_delay", want.front_delay, got.front_delay);
					check_field("front_period", want.front_period, got.front_period);
					check_field("entry_count", 32'(want.entry_count),
					            32'(got.entry_count));
				end
			end
			if (req_mon.valid && req_mon.ready)
				queue_reports.push_back(apply_timer_op(req_mon.data));
			waiting = queue_reports.size();
		end
	end

endmodule

// ===== tb/delta_list_timer_queue_tb.sv =====
`timescale 1ns / 1ps

module delta_list_timer_queue_tb;
	import dltq_pkg::*;

	localparam int ITEMS        = 1700;
	localparam int IDLE_LIMIT   = 4000;
	localparam int HOLD_START   = 3000;
	localparam int HOLD_LEN     = 400;
	localparam int DRAIN_CYCLES = 40;

	logic clk = 1'b0;
	logic arst_n;

	dltq_in_if  req_ch ();
	dltq_out_if rsp_ch ();

	int mismatch_count;
	int reports_waiting;
	int burst_left;
	int idle_cycles;

	delta_list_timer_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	dltq_checker chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_mon         (req_ch),
		.rsp_mon         (rsp_ch),
		.mismatch_count  (mismatch_count),
		.reports_waiting (reports_waiting)
	);

	always #5 clk = ~clk;

	function automatic in_item_t make_item(op_t op, logic [31:0] id, logic [31:0] dly,
	                                       logic [31:0] per);
		in_item_t it;
		it.operation = op;
		it.task_id   = id;
		it.delay     = dly;
		it.period    = per;
		return it;
	endfunction

	// Ids come mostly from a small pool so that removes hit and duplicates occur.
	function automatic logic [31:0] pick_id();
		int p;
		p = $urandom_range(0, 99);
		if (p < 80)
			return $urandom_range(0, 5);
		else if (p < 88)
			return 32'hFFFF_FFFF - $urandom_range(0, 1);
		else
			return $urandom;
	endfunction

	function automatic logic [31:0] pick_delay();
		int p;
		p = $urandom_range(0, 99);
		if (p < 40)
			return $urandom_range(0, 15);
		else if (p < 60)
			return $urandom_range(0, 1000);
		else if (p < 85)
			return $urandom;
		else if (p < 90)
			return 32'h0;
		else if (p < 95)
			return 32'hFFFF_FFFF;
		else
			return 32'hFFFF_FFF0 + $urandom_range(0, 15);
	endfunction

	function automatic logic [31:0] pick_period();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50)
			return $urandom;
		else if (p < 75)
			return $urandom_range(0, 100);
		else if (p < 88)
			return 32'h0;
		else
			return 32'hFFFF_FFFF;
	endfunction

	// Phase 0 fills the queue, phase 1 drains it, phase 2 is a balanced mix.
	function automatic in_item_t random_item(int phase);
		int p;
		op_t op;
		p = $urandom_range(0, 99);
		case (phase)
			0:       op = (p < 75) ? OP_INSERT : (p < 85) ? OP_REMOVE : (p < 95) ? OP_POP : OP_NOP;
			1:       op = (p < 20) ? OP_INSERT : (p < 50) ? OP_REMOVE : (p < 95) ? OP_POP : OP_NOP;
			default: op = (p < 40) ? OP_INSERT : (p < 65) ? OP_REMOVE : (p < 95) ? OP_POP : OP_NOP;
		endcase
		return make_item(op, pick_id(), pick_delay(), pick_period());
	endfunction

	task automatic push_item(in_item_t it);
		int gap;
		req_ch.valid <= 1'b1;
		req_ch.data  <= it;
		do @(posedge clk); while (!req_ch.ready);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
	endtask

	initial begin
		int phase;
		arst_n       <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.data  <= '0;
		rsp_ch.ready <= 1'b0;
		burst_left = $urandom_range(1, 30);
		phase = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty queue cases, field extremes, equal totals,
		// duplicate ids, a full queue and an absent id.
		push_item(make_item(OP_POP, 32'h0, 32'h0, 32'h0));
		push_item(make_item(OP_REMOVE, 32'd5, 32'h0, 32'h0));
		push_item(make_item(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		push_item(make_item(OP_INSERT, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		push_item(make_item(OP_INSERT, 32'hFFFF_FFFF, 32'h0, 32'h0));
		push_item(make_item(OP_INSERT, 32'd1, 32'd10, 32'd1));
		push_item(make_item(OP_INSERT, 32'd2, 32'd10, 32'd2));
		push_item(make_item(OP_INSERT, 32'd1, 32'd5, 32'd3));
		push_item(make_item(OP_INSERT, 32'd3, 32'd0, 32'd4));
		push_item(make_item(OP_NOP, 32'h0, 32'h0, 32'h0));
		push_item(make_item(OP_REMOVE, 32'd1, 32'h0, 32'h0));
		for (int k = 0; k < 11; k++)
			push_item(make_item(OP_INSERT, 32'd8 + k, (k == 5) ? 32'h8000_0000 : 32'd1000 * k,
			                    32'hA5A5_0000 + k));
		push_item(make_item(OP_INSERT, 32'd99, 32'd7, 32'd7));
		push_item(make_item(OP_REMOVE, 32'd77, 32'h0, 32'h0));
		push_item(make_item(OP_POP, 32'h0, 32'h0, 32'h0));

		for (int n = 0; n < ITEMS; n++) begin
			if (n % 60 == 0)
				phase = $urandom_range(0, 2);
			push_item(random_item(phase));
		end
		req_ch.valid <= 1'b0;

		@(posedge clk);
		while (reports_waiting != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Result side: segments of different stall patterns, plus one long hold-off
	// that lets the block fill up and push back on its input.
	initial begin
		int cyc;
		int mode;
		int seg;
		int per;
		logic rdy;
		cyc = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			mode = $urandom_range(0, 3);
			seg  = $urandom_range(20, 200);
			per  = $urandom_range(1, 8);
			for (int n = 0; n < seg; n++) begin
				if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN)
					rdy = 1'b0;
				else
					case (mode)
						0:       rdy = 1'b1;
						1:       rdy = ($urandom_range(0, 9) < 7);
						2:       rdy = ($urandom_range(0, 9) < 3);
						default: rdy = ((cyc / per) % 2) == 0;
					endcase
				rsp_ch.ready <= rdy;
				@(posedge clk);
				cyc++;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

// ===== sim.f =====
src/dltq_pkg.sv
src/dltq_in_if.sv
src/dltq_out_if.sv
src/dltq_cell.sv
src/delta_list_timer_queue.sv
tb/dltq_checker.sv
tb/delta_list_timer_queue_tb.sv
